[rtl/utd_pkg.sv]
// Package of the UTF-8 to UTF-16 decoder: byte constants, queue sizing
// and the entry type passed from the front to the back. No dependencies.
package utd_pkg;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;
  localparam logic [1:0] CONT_TAG = 2'b10;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [20:0] CP_MAX1 = 21'h00007F;
  localparam logic [20:0] CP_MAX2 = 21'h0007FF;
  localparam logic [20:0] CP_MAX3 = 21'h00FFFF;
  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [20:0] SURR_MIN = 21'h00D800;
  localparam logic [20:0] SURR_MAX = 21'h00DFFF;
  localparam logic [20:0] PLANE1_BASE = 21'h010000;
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;
    logic pair;
    logic error;
    logic fin;
  } res_entry_t;

endpackage

[rtl/utd_if.sv]
// Channel interfaces of the UTF-8 to UTF-16 decoder: the byte input and
// the code unit output, each with valid and ready. No dependencies.
interface utd_in_if;
  logic valid;
  logic ready;
  logic [7:0] byte_value;
  logic last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface utd_out_if;
  logic valid;
  logic ready;
  logic [15:0] code_unit;
  logic error;
  logic string_end;
  logic run_last;

  modport source (output valid, output code_unit, output error, output string_end,
                  output run_last, input ready);
  modport sink (input valid, input code_unit, input error, input string_end,
                input run_last, output ready);
endinterface

[rtl/utf8_to_utf16_decoder.sv]
// Top level of the UTF-8 to UTF-16 decoder: front, queue and back.
// Depends on utd_pkg, utd_if, utd_front, utd_queue and utd_back.
//
// The decoder takes one UTF-8 byte per clock cycle and gives zero, one or
// two UTF-16 results for it: a byte inside a sequence gives none, a
// finished character up to U+FFFF or an error gives one, and a character
// above U+FFFF gives a high and a low surrogate as two consecutive output
// results. The front checks and collects each byte combinationally and
// hands results to a four-entry queue; the back drains the queue through a
// registered output, so a result passes through the queue and the output
// register after its byte. Input stalls only when the queue is full, which
// happens only when the output is held back, since a surrogate pair needs
// four input bytes and so never outpaces one output per cycle. After an
// error the rest of the string is dropped and its last byte gives one
// closing error result.
module utf8_to_utf16_decoder
  import utd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  utd_in_if.sink     in_ch,
  utd_out_if.source  out_ch
);

  logic       push;
  res_entry_t push_ent;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  res_entry_t head_ent;

  utd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  utd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ent   (push_ent),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ent   (head_ent)
  );

  utd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ent   (head_ent),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[rtl/utd_front.sv]
// Front of the decoder: accepts bytes, collects and checks UTF-8 sequences
// and pushes one result entry per finished character or error.
// Depends on utd_pkg and utd_in_if.
module utd_front
  import utd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  utd_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output res_entry_t push_ent
);

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  left_r, left_nxt;
  logic [2:0]  len_r, len_nxt;
  logic        disc_r, disc_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic [20:0] cont_code;
  logic [1:0]  left_dec;
  logic [19:0] cp_off;
  logic        do_fail;
  logic        bad_cp;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign b = in_ch.byte_value;
  assign fin = in_ch.last_byte;
  assign cont_code = {partial_r[14:0], b[5:0]};
  assign left_dec = left_r - 2'd1;
  assign cp_off = 20'(cont_code - PLANE1_BASE);

  always_comb begin
    bad_cp = ((len_r == SEQ_LEN2) && (cont_code <= CP_MAX1)) ||
             ((len_r == SEQ_LEN3) && (cont_code <= CP_MAX2)) ||
             ((len_r == SEQ_LEN4) && (cont_code <= CP_MAX3)) ||
             (cont_code > CP_MAX) ||
             ((cont_code >= SURR_MIN) && (cont_code <= SURR_MAX));
  end

  always_comb begin
    partial_nxt = partial_r;
    left_nxt = left_r;
    len_nxt = len_r;
    disc_nxt = disc_r;
    push = 1'b0;
    push_ent = '0;
    do_fail = 1'b0;
    if (accept) begin
      priority if (disc_r) begin
        if (fin) begin
          push = 1'b1;
          push_ent.error = 1'b1;
          push_ent.fin = 1'b1;
          disc_nxt = 1'b0;
        end
      end else if (left_r == 2'd0) begin
        priority if (b <= ASCII_MAX) begin
          push = 1'b1;
          push_ent.unit_lo = {8'd0, b};
          push_ent.fin = fin;
          partial_nxt = '0;
          len_nxt = '0;
        end else if (b < LEAD2_MIN || b > LEAD4_MAX) begin
          do_fail = 1'b1;
        end else if (fin) begin
          do_fail = 1'b1;
        end else if (b <= LEAD2_MAX) begin
          partial_nxt = {16'd0, b[4:0]};
          len_nxt = SEQ_LEN2;
          left_nxt = 2'd1;
        end else if (b <= LEAD3_MAX) begin
          partial_nxt = {17'd0, b[3:0]};
          len_nxt = SEQ_LEN3;
          left_nxt = 2'd2;
        end else begin
          partial_nxt = {18'd0, b[2:0]};
          len_nxt = SEQ_LEN4;
          left_nxt = 2'd3;
        end
      end else begin
        priority if (b[7:6] != CONT_TAG) begin
          do_fail = 1'b1;
        end else if (left_dec != 2'd0) begin
          if (fin) begin
            do_fail = 1'b1;
          end else begin
            partial_nxt = cont_code;
            left_nxt = left_dec;
          end
        end else if (bad_cp) begin
          do_fail = 1'b1;
        end else begin
          push = 1'b1;
          push_ent.fin = fin;
          partial_nxt = '0;
          left_nxt = 2'd0;
          len_nxt = '0;
          if (cont_code <= CP_MAX3) begin
            push_ent.unit_lo = cont_code[15:0];
          end else begin
            push_ent.pair = 1'b1;
            push_ent.unit_hi = {HI_SURR_TAG, cp_off[19:10]};
            push_ent.unit_lo = {LO_SURR_TAG, cp_off[9:0]};
          end
        end
      end
      if (do_fail) begin
        push = 1'b1;
        push_ent = '0;
        push_ent.error = 1'b1;
        push_ent.fin = fin;
        partial_nxt = '0;
        left_nxt = 2'd0;
        len_nxt = '0;
        disc_nxt = !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r <= '0;
      len_r <= '0;
      disc_r <= 1'b0;
    end else begin
      partial_r <= partial_nxt;
      left_r <= left_nxt;
      len_r <= len_nxt;
      disc_r <= disc_nxt;
    end
  end

  a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (left_r == 2'd0) && (len_r == 3'd0))
    else $error("discarding while a sequence is open");

endmodule

[rtl/utd_queue.sv]
// Short queue of result entries between the decoder front and back.
// Depends on utd_pkg.
module utd_queue
  import utd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_entry_t push_ent,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output res_entry_t head_ent
);

  res_entry_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_ent = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/utd_back.sv]
// Back of the decoder: turns queue entries into result items, sending a
// surrogate pair over two items, through a registered output stage.
// Depends on utd_pkg and utd_out_if.
module utd_back
  import utd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  res_entry_t head_ent,
  output logic       pop,
  utd_out_if.source  out_ch
);

  logic        out_valid_r;
  logic [15:0] unit_r;
  logic        error_r;
  logic        end_r;
  logic        last_r;
  logic        phase_r, phase_nxt;
  logic        load;
  logic        first_half;

  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign first_half = head_ent.pair && !phase_r;
  assign pop = load && !first_half;

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = first_half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= first_half ? head_ent.unit_hi : head_ent.unit_lo;
      error_r <= head_ent.error;
      end_r <= head_ent.fin && !first_half;
      last_r <= !first_half;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.code_unit = unit_r;
  assign out_ch.error = error_r;
  assign out_ch.string_end = end_r;
  assign out_ch.run_last = last_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && error_r) |-> (unit_r == 16'd0) && last_r)
    else $error("error result with nonzero unit or not last");

  a_first_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> !error_r && !end_r && phase_r)
    else $error("bad first half of a surrogate pair");

  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> head_valid && head_ent.pair)
    else $error("second half pending without its entry");

endmodule

[sim/tb_top.sv]
// Self-checking testbench of the UTF-8 to UTF-16 decoder: directed and random
// byte strings with random gaps on both channels, checked against a predictor.
// Depends on utd_pkg, utd_if and the decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import utd_pkg::*;

  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [15:0] code_unit;
    logic error;
    logic string_end;
    logic run_last;
  } utf16_unit_t;

  class utf16_scoreboard;
    logic [20:0] partial;
    logic [1:0] left;
    logic [2:0] seq_len;
    bit discarding;
    utf16_unit_t pending[$];
    int mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      partial = '0;
      left = '0;
      seq_len = '0;
      discarding = 1'b0;
    endfunction

    function void expect_unit(logic [15:0] cu, logic err, logic str_end, logic run_last);
      pending.insert(pending.size(), utf16_unit_t'{cu, err, str_end, run_last});
    endfunction

    function void reject(logic fin);
      expect_unit(16'h0000, 1'b1, fin, 1'b1);
      clear();
      discarding = !fin;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      logic [20:0] cp;
      if (discarding) begin
        if (fin) begin
          expect_unit(16'h0000, 1'b1, 1'b1, 1'b1);
          clear();
        end
        return;
      end
      if (left == 2'd0) begin
        if (b <= ASCII_MAX) begin
          expect_unit({8'h00, b}, 1'b0, fin, 1'b1);
          clear();
          return;
        end
        if (b < LEAD2_MIN || b > LEAD4_MAX) begin
          reject(fin);
          return;
        end
        if (b <= LEAD2_MAX) begin
          partial = {16'h0000, b[4:0]};
          seq_len = SEQ_LEN2;
        end else if (b <= LEAD3_MAX) begin
          partial = {17'h00000, b[3:0]};
          seq_len = SEQ_LEN3;
        end else begin
          partial = {18'h00000, b[2:0]};
          seq_len = SEQ_LEN4;
        end
        left = 2'(seq_len - 3'd1);
        if (fin) reject(fin);
        return;
      end
      if (b[7:6] != CONT_TAG) begin
        reject(fin);
        return;
      end
      partial = {partial[14:0], b[5:0]};
      left = left - 2'd1;
      if (left != 2'd0) begin
        if (fin) reject(fin);
        return;
      end
      cp = partial;
      if ((seq_len == SEQ_LEN2 && cp <= CP_MAX1) || (seq_len == SEQ_LEN3 && cp <= CP_MAX2) ||
          (seq_len == SEQ_LEN4 && cp <= CP_MAX3) || cp > CP_MAX ||
          (cp >= SURR_MIN && cp <= SURR_MAX)) begin
        reject(fin);
        return;
      end
      clear();
      if (cp <= CP_MAX3) begin
        expect_unit(cp[15:0], 1'b0, fin, 1'b1);
      end else begin
        cp = cp - PLANE1_BASE;
        expect_unit({HI_SURR_TAG, cp[19:10]}, 1'b0, 1'b0, 1'b0);
        expect_unit({LO_SURR_TAG, cp[9:0]}, 1'b0, fin, 1'b1);
      end
    endfunction

    function void check_unit(utf16_unit_t got);
      utf16_unit_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: unit %h error %b end %b run_last %b",
                   got.code_unit, got.error, got.string_end, got.run_last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected unit %h error %b end %b run_last %b, got %h %b %b %b",
                   want.code_unit, want.error, want.string_end, want.run_last,
                   got.code_unit, got.error, got.string_end, got.run_last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit calm;
  int cycles;
  utf16_scoreboard sb = new();

  utd_in_if in_ch();
  utd_out_if out_ch();

  utf8_to_utf16_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[utf8_to_utf16_decoder] ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_unit(utf16_unit_t'{out_ch.code_unit, out_ch.error, out_ch.string_end,
                                  out_ch.run_last});
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.last_byte <= fin;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_byte(b, fin);
  endtask

  function automatic void encode(input logic [20:0] cp, input int len, ref logic [7:0] q[$]);
    case (len)
      1: q.insert(q.size(), cp[7:0]);
      2: begin
        q.insert(q.size(), {3'b110, cp[10:6]});
        q.insert(q.size(), {CONT_TAG, cp[5:0]});
      end
      3: begin
        q.insert(q.size(), {4'b1110, cp[15:12]});
        q.insert(q.size(), {CONT_TAG, cp[11:6]});
        q.insert(q.size(), {CONT_TAG, cp[5:0]});
      end
      default: begin
        q.insert(q.size(), {5'b11110, cp[20:18]});
        q.insert(q.size(), {CONT_TAG, cp[17:12]});
        q.insert(q.size(), {CONT_TAG, cp[11:6]});
        q.insert(q.size(), {CONT_TAG, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] valid_cp(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        do cp = 21'($urandom_range('h800, 'hFFFF)); while (cp >= SURR_MIN && cp <= SURR_MAX);
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic void add_char(ref logic [7:0] q[$]);
    logic [20:0] edges[8] = '{21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000, 21'hFFFF,
                              21'h10000, 21'h10FFFF};
    logic [20:0] cp;
    logic [7:0] b;
    int kind, len, start, idx, cut;
    kind = $urandom_range(0, 99);
    len = $urandom_range(2, 4);
    start = q.size();
    if (kind < 6) begin
      cp = edges[3'($urandom_range(0, 7))];
      encode(cp, cp <= CP_MAX2 ? 2 : (cp <= CP_MAX3 ? 3 : 4), q);
    end else if (kind < 75) begin
      len = $urandom_range(1, 4);
      encode(valid_cp(len), len, q);
    end else if (kind < 80) begin
      cp = 21'($urandom_range(0, len == 2 ? 'h7F : (len == 3 ? 'h7FF : 'hFFFF)));
      encode(cp, len, q);
    end else if (kind < 84) begin
      encode(21'($urandom_range(SURR_MIN, SURR_MAX)), 3, q);
    end else if (kind < 87) begin
      encode(21'($urandom_range('h110000, 'h1FFFFF)), 4, q);
    end else if (kind < 92) begin
      encode(valid_cp(len), len, q);
      idx = start + $urandom_range(1, len - 1);
      do b = 8'($urandom()); while (b[7:6] == CONT_TAG);
      q[idx] = b;
    end else if (kind < 96) begin
      encode(valid_cp(len), len, q);
      cut = $urandom_range(1, len - 1);
      repeat (cut) void'(q.pop_back());
    end else begin
      q.insert(q.size(), 8'($urandom()));
    end
  endfunction

  task automatic run_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hE0, 1'b1);
  endtask

  task automatic run_random();
    logic [7:0] text[$];
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      text.delete();
      repeat ($urandom_range(1, 6)) add_char(text);
      calm = ($urandom_range(0, 9) == 0);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      sent += text.size();
    end
  endtask

  initial begin
    calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_value = '0;
    in_ch.last_byte = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[utf8_to_utf16_decoder] OK");
    end else begin
      $display("[utf8_to_utf16_decoder] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/utd_pkg.sv
rtl/utd_if.sv
rtl/utd_front.sv
rtl/utd_queue.sv
rtl/utd_back.sv
rtl/utf8_to_utf16_decoder.sv
sim/tb_top.sv
